>>> sv/biq_pkg.sv
// Shared constants, command codes and the controller-to-datapath command type.
package biq_pkg;

  // Default field widths
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 20;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_B0 = 3'd0;
  localparam cfg_index_t REG_B1 = 3'd1;
  localparam cfg_index_t REG_B2 = 3'd2;
  localparam cfg_index_t REG_A1 = 3'd3;
  localparam cfg_index_t REG_A2 = 3'd4;

  // Multiplier operand pairs
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_XB0 = 3'd0;
  localparam mul_sel_t MUL_XB1 = 3'd1;
  localparam mul_sel_t MUL_XB2 = 3'd2;
  localparam mul_sel_t MUL_YA1 = 3'd3;
  localparam mul_sel_t MUL_YA2 = 3'd4;

  // Accumulator operations
  typedef logic [2:0] acc_op_t;
  localparam acc_op_t ACC_HOLD     = 3'd0;
  localparam acc_op_t ACC_ADD_D1   = 3'd1;
  localparam acc_op_t ACC_ADD_HALF = 3'd2;
  localparam acc_op_t ACC_LOAD_P   = 3'd3;
  localparam acc_op_t ACC_SUB_P    = 3'd4;
  localparam acc_op_t ACC_ADD_D2   = 3'd5;

  typedef struct packed {
    logic     load_x;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     load_y;
    logic     load_n2;
    logic     commit;
  } biq_cmd_t;

endpackage

>>> sv/biq_ctrl.sv
// Sequencer for the biquad section: handshakes and per-cycle datapath commands.
module biq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_in_valid,
  output logic             sample_in_ready,
  output logic             sample_out_valid,
  input  logic             sample_out_ready,
  output biq_pkg::biq_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;
  localparam logic [2:0] ST_FB1  = 3'd4;
  localparam logic [2:0] ST_SUB1 = 3'd5;
  localparam logic [2:0] ST_ADD2 = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_blocked;

  assign sample_in_ready = (state == ST_IDLE);
  assign out_blocked     = sample_out_valid && !sample_out_ready;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = biq_pkg::MUL_XB0;
    cmd.acc_op  = biq_pkg::ACC_HOLD;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (sample_in_valid) begin
          cmd.load_x  = 1'b1;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = biq_pkg::MUL_XB0;
          state_next  = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biq_pkg::MUL_XB1;
        cmd.acc_op  = biq_pkg::ACC_ADD_D1;
        state_next  = ST_RND;
      end
      ST_RND: begin
        cmd.acc_op = biq_pkg::ACC_ADD_HALF;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold until the previous result has been taken
        if (!out_blocked) begin
          cmd.load_y = 1'b1;
          state_next = ST_FB1;
        end
      end
      ST_FB1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biq_pkg::MUL_YA1;
        cmd.acc_op  = biq_pkg::ACC_LOAD_P;
        state_next  = ST_SUB1;
      end
      ST_SUB1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biq_pkg::MUL_XB2;
        cmd.acc_op  = biq_pkg::ACC_SUB_P;
        state_next  = ST_ADD2;
      end
      ST_ADD2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biq_pkg::MUL_YA2;
        cmd.acc_op  = biq_pkg::ACC_ADD_D2;
        cmd.load_n2 = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      sample_out_valid <= 1'b0;
    end else begin
      state            <= state_next;
      sample_out_valid <= cmd.load_y || out_blocked;
    end
  end

endmodule

>>> sv/biq_datapath.sv
// Biquad datapath: coefficient registers, shared multiplier, accumulator and delay terms.
module biq_datapath #(
  parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  biq_pkg::biq_cmd_t                    cmd,
  input  logic                                 cfg_we,
  input  biq_pkg::cfg_index_t                  cfg_index,
  input  logic signed [COEF_FRAC_BITS+3:0]     cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  output logic signed [SAMPLE_BITS-1:0]        sample_out
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = COEF_FRAC_BITS;
  localparam int C     = F + 4;
  localparam int D     = S + C;
  localparam int ACC_W = (D + 2 < 64) ? D + 2 : 64;
  localparam int SUM_W = ACC_W + 1;

  localparam logic signed [C-1:0] COEF_ONE = {{(C-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] D_MAX = {{(ACC_W-D+1){1'b0}}, {(D-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] D_MIN = ~D_MAX;
  localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  // clamp a one-bit-grown sum back to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[SUM_W-1] != v[SUM_W-2]) begin
      r = v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [D-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > D_MAX) begin
      r = D_MAX;
    end else if (v < D_MIN) begin
      r = D_MIN;
    end else begin
      r = v;
    end
    return r[D-1:0];
  endfunction

  logic signed [C-1:0]     b0, b1, b2, a1, a2;
  logic signed [S-1:0]     x;
  logic signed [S-1:0]     y;
  logic signed [D-1:0]     prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [D-1:0]     n2;
  logic signed [D-1:0]     delay_one;
  logic signed [D-1:0]     delay_two;

  logic signed [S-1:0]     x_src;
  logic signed [S-1:0]     mul_a;
  logic signed [C-1:0]     mul_b;
  logic signed [SUM_W-1:0] sum_a, sum_b;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [S-1:0]     y_next;
  logic signed [ACC_W-1:0] n2_sat;

  assign sample_out = y;
  assign x_src      = cmd.load_x ? sample_in : x;

  // multiplier operand selection
  always_comb begin
    mul_a = x_src;
    mul_b = b0;
    case (cmd.mul_sel)
      biq_pkg::MUL_XB0: begin
        mul_a = x_src;
        mul_b = b0;
      end
      biq_pkg::MUL_XB1: begin
        mul_a = x_src;
        mul_b = b1;
      end
      biq_pkg::MUL_XB2: begin
        mul_a = x_src;
        mul_b = b2;
      end
      biq_pkg::MUL_YA1: begin
        mul_a = y;
        mul_b = a1;
      end
      biq_pkg::MUL_YA2: begin
        mul_a = y;
        mul_b = a2;
      end
      default: begin
        mul_a = x_src;
        mul_b = b0;
      end
    endcase
  end

  // accumulator adder operands
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    case (cmd.acc_op)
      biq_pkg::ACC_ADD_D1: begin
        sum_a = SUM_W'(prod);
        sum_b = SUM_W'(delay_one);
      end
      biq_pkg::ACC_ADD_HALF: begin
        sum_a = SUM_W'(acc);
        sum_b = SUM_W'(HALF);
      end
      biq_pkg::ACC_SUB_P: begin
        sum_a = SUM_W'(acc);
        sum_b = -SUM_W'(prod);
      end
      biq_pkg::ACC_ADD_D2: begin
        sum_a = SUM_W'(acc);
        sum_b = SUM_W'(delay_two);
      end
      default: begin
        sum_a = '0;
        sum_b = '0;
      end
    endcase
  end

  assign acc_sat = sat_acc(sum_a + sum_b);
  assign n2_sat  = sat_acc(SUM_W'(n2) - SUM_W'(prod));

  // round has already been added; floor then clamp to the sample range
  assign acc_shr = acc >>> F;
  always_comb begin
    if (acc_shr > Y_MAX) begin
      y_next = Y_MAX[S-1:0];
    end else if (acc_shr < Y_MIN) begin
      y_next = Y_MIN[S-1:0];
    end else begin
      y_next = acc_shr[S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0        <= COEF_ONE;
      b1        <= '0;
      b2        <= '0;
      a1        <= '0;
      a2        <= '0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          biq_pkg::REG_B0: b0 <= cfg_data;
          biq_pkg::REG_B1: b1 <= cfg_data;
          biq_pkg::REG_B2: b2 <= cfg_data;
          biq_pkg::REG_A1: a1 <= cfg_data;
          biq_pkg::REG_A2: a2 <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        delay_one <= sat_delay(acc);
        delay_two <= sat_delay(n2_sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= sample_in;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (cmd.acc_op)
      biq_pkg::ACC_HOLD:   ;
      biq_pkg::ACC_LOAD_P: acc <= ACC_W'(prod);
      default:             acc <= acc_sat;
    endcase
    if (cmd.load_y) begin
      y <= y_next;
    end
    if (cmd.load_n2) begin
      n2 <= prod;
    end
  end

endmodule

>>> sv/biquad_iir_section.sv
// Results: each result is registered in the emit step, which holds while the previous
//   result is still waiting. A new item is accepted only after the last one commits.
// Datapath: the single shared multiplier forms the five products in turn and the
//   accumulator walks the feed-forward and feedback sums.
// Reset (synchronous, active high): b0 = 1.0, other coefficients 0, both delay terms
//   zero, no result pending, input ready.
// Top level of one transposed direct form II biquad section.
module biquad_iir_section #(
  parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes, to be made only while idle; enforcing this is left to the user
  input  logic                             cfg_we,
  input  logic [biq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic signed [COEF_FRAC_BITS+3:0] cfg_data,
  // input sample channel
  input  logic                             sample_in_valid,
  output logic                             sample_in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in,
  // filtered sample channel
  output logic                             sample_out_valid,
  input  logic                             sample_out_ready,
  output logic signed [SAMPLE_BITS-1:0]    sample_out
);

  // Per-cycle commands from the sequencer to the datapath. The controller
  // steps through: accept+x*b0, add delay_one, add rounding half, emit y,
  // load x*b1, subtract y*a1, add delay_two, commit the new delay terms.
  biq_pkg::biq_cmd_t cmd;

  biq_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .sample_in_valid  (sample_in_valid),
    .sample_in_ready  (sample_in_ready),
    .sample_out_valid (sample_out_valid),
    .sample_out_ready (sample_out_ready),
    .cmd              (cmd)
  );

  // The result register doubles as the feedback operand y, so it is only
  // overwritten once the previous item has been taken.
  biq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_in_valid && sample_in_ready |=> !sample_in_ready)
    else $error("input ready right after accepting an item");

  // Never overwrite a result that is still waiting to be taken.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_y |-> !(sample_out_valid && !sample_out_ready))
    else $error("result overwritten before it was taken");

  // Committing the delay terms returns the block to idle.
  a_commit_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> sample_in_ready)
    else $error("not idle after delay commit");

  // A new result is only raised by the emit step.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_out_valid) |-> $past(cmd.load_y))
    else $error("result valid without an emit step");
`endif

endmodule

>>> tb/sv/biquad_section_checker.sv
// Checker for the biquad section: predicts every filtered sample and compares it.
module biquad_section_checker
  import biq_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  cfg_index_t                          cfg_index,
  input  logic signed [COEF_FRAC_BITS_DEF+3:0] cfg_data,
  input  logic                                sample_in_valid,
  input  logic                                sample_in_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0]   sample_in,
  input  logic                                sample_out_valid,
  input  logic                                sample_out_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0]   sample_out,
  output int                                  mismatch_count,
  output int                                  samples_in_flight,
  output int                                  samples_checked
);

  localparam int SW   = SAMPLE_BITS_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam int DW   = SW + FRAC + 4;

  longint coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  longint delay_one, delay_two;
  logic signed [SW-1:0] expected_samples[$];
  int errors;
  int checked;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // One step of the transposed direct form II section; advances the delay terms.
  function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x);
    longint xs;
    longint acc;
    longint y;
    xs  = longint'(x);
    // round half up, then floor back to sample units
    acc = (xs * coef_b0 + delay_one + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    y   = clamp(acc, SW);
    // feedback uses the saturated output
    delay_one = clamp(xs * coef_b1 - y * coef_a1 + delay_two, DW);
    delay_two = clamp(xs * coef_b2 - y * coef_a2, DW);
    return y[SW-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic signed [SW-1:0] want;
    if (rst) begin
      coef_b0   = longint'(1) <<< FRAC;
      coef_b1   = 0;
      coef_b2   = 0;
      coef_a1   = 0;
      coef_a2   = 0;
      delay_one = 0;
      delay_two = 0;
      expected_samples.delete();
      errors    = 0;
      checked   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_B0: coef_b0 = longint'(cfg_data);
          REG_B1: coef_b1 = longint'(cfg_data);
          REG_B2: coef_b2 = longint'(cfg_data);
          REG_A1: coef_a1 = longint'(cfg_data);
          REG_A2: coef_a2 = longint'(cfg_data);
          default: ;
        endcase
      end
      if (sample_out_valid && sample_out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected item, expected none, got %0d", sample_out);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (sample_out !== want) begin
            $error("sample_out mismatch: expected %0d, got %0d", want, sample_out);
            errors++;
          end
        end
      end
      if (sample_in_valid && sample_in_ready)
        expected_samples.push_back(filter_sample(sample_in));
    end
    mismatch_count    <= errors;
    samples_in_flight <= expected_samples.size();
    samples_checked   <= checked;
  end

endmodule

>>> tb/sv/tb_biquad_iir_section.sv
// Testbench top for the biquad section: clock, reset, stimulus, coefficient phases, verdict.
module tb_biquad_iir_section;
  import biq_pkg::*;

  localparam int SW   = SAMPLE_BITS_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam int CW   = COEF_FRAC_BITS_DEF + 4;
  localparam int ONE  = 1 << FRAC;   // 1.0 in Q4.F

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  // indexes past the last coefficient; the block must drop these writes
  localparam cfg_index_t REG_SPARE_LO = 3'd5;
  localparam cfg_index_t REG_SPARE_HI = 3'd7;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 47;
  localparam int WAIT_MAX      = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int RUN_LIMIT     = 2_000_000;   // time units, far beyond the slowest run

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  cfg_index_t           cfg_index;
  logic signed [CW-1:0] cfg_data;
  logic                 sample_in_valid;
  logic                 sample_in_ready;
  logic signed [SW-1:0] sample_in;
  logic                 sample_out_valid;
  logic                 sample_out_ready;
  logic signed [SW-1:0] sample_out;

  int mismatch_count;
  int samples_in_flight;
  int samples_checked;
  int samples_sent;
  int coef_sets;
  int out_stall;
  int out_draw;
  bit steady;   // when set, neither side idles

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  biquad_iir_section u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_in_valid  (sample_in_valid),
    .sample_in_ready  (sample_in_ready),
    .sample_in        (sample_in),
    .sample_out_valid (sample_out_valid),
    .sample_out_ready (sample_out_ready),
    .sample_out       (sample_out)
  );

  biquad_section_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .sample_in_valid   (sample_in_valid),
    .sample_in_ready   (sample_in_ready),
    .sample_in         (sample_in),
    .sample_out_valid  (sample_out_valid),
    .sample_out_ready  (sample_out_ready),
    .sample_out        (sample_out),
    .mismatch_count    (mismatch_count),
    .samples_in_flight (samples_in_flight),
    .samples_checked   (samples_checked)
  );

  // Cycles to idle before the next item on either side.
  function automatic int idle_cycles();
    if (steady) return 0;
    return $urandom_range(0, WAIT_MAX);
  endfunction

  // Small magnitudes keep the filter near stable; full range drives it into saturation.
  function automatic logic signed [CW-1:0] rand_coef(input bit full);
    if (full) return CW'($urandom);
    return CW'(int'($urandom_range(0, 2 * ONE)) - ONE);
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SW'(int'($urandom_range(0, 510)) - 255);
      default: return SW'($urandom);
    endcase
  endfunction

  // Sink side: after each item taken, hold ready low for a random stall.
  always @(posedge clk) begin
    if (rst) begin
      sample_out_ready <= 1'b0;
      out_stall        <= 0;
    end else if (sample_out_valid && sample_out_ready) begin
      out_draw = idle_cycles();
      sample_out_ready <= (out_draw == 0);
      out_stall        <= out_draw;
    end else if (!sample_out_ready) begin
      if (out_stall <= 1) sample_out_ready <= 1'b1;
      if (out_stall > 0) out_stall <= out_stall - 1;
    end
  end

  // Offer one item; valid stays high into the next item when no idle is drawn.
  task automatic send_sample(input logic signed [SW-1:0] x);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      sample_in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_in_valid <= 1'b1;
    sample_in       <= x;
    @(posedge clk);
    while (!sample_in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid and hold until every filtered sample has come back and the block is idle.
  task automatic drain_pipeline();
    sample_in_valid <= 1'b0;
    @(posedge clk);
    while (samples_in_flight != 0 || !sample_in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic signed [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Load all five coefficients while idle, plus one write to a spare index.
  task automatic load_coefs(input logic signed [CW-1:0] b0, input logic signed [CW-1:0] b1,
                            input logic signed [CW-1:0] b2, input logic signed [CW-1:0] a1,
                            input logic signed [CW-1:0] a2);
    drain_pipeline();
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(cfg_index_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CW'($urandom));
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_B0;
    cfg_data        <= '0;
    sample_in_valid <= 1'b0;
    sample_in       <= '0;
    steady           = 1'b0;
    samples_sent     = 0;
    coef_sets        = 1;   // the reset set counts as the first
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients pass samples straight through: hit the field extremes.
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(SW'(0));
    send_sample(SW'(1));
    send_sample(SW'(-1));

    // Half gain puts odd samples exactly on the rounding midpoint.
    load_coefs(CW'(ONE / 2), CW'(0), CW'(0), CW'(0), CW'(0));
    send_sample(SW'(1));
    send_sample(SW'(-1));
    send_sample(SW'(3));
    send_sample(SW'(-3));
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Extreme coefficients: saturate the output and both delay terms.
    load_coefs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    load_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Gentle low-pass: an impulse and then silence shows the feedback ringing out.
    load_coefs(CW'(ONE / 4), CW'(ONE / 2), CW'(ONE / 4), CW'(-ONE / 2), CW'(ONE / 8));
    send_sample(S_MAX);
    repeat (4) send_sample(SW'(0));

    // Random phases alternate near-stable and full-range coefficient sets.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_coefs(rand_coef((p % 2) == 1), rand_coef((p % 2) == 1), rand_coef((p % 2) == 1),
                 rand_coef((p % 2) == 1), rand_coef((p % 2) == 1));
      steady = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off mid-phase until the pipeline is empty
        if (p == 2 && k == PHASE_ITEMS / 2) drain_pipeline();
        send_sample(rand_sample());
      end
      steady = 1'b0;
    end

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples over %0d coefficient sets, with extremes and rounding ties.",
             samples_sent, coef_sets);
    $display("Compared %0d filtered samples, %0d mismatches.", samples_checked, mismatch_count);
    if (mismatch_count == 0 && samples_in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL");
    $finish;
  end

endmodule
